### rtl/ground_motion_intensity_measures_core_assert.svh
// Assertion macros used by the checker file of the ground-motion block.
`ifndef GROUND_MOTION_INTENSITY_MEASURES_CORE_ASSERT_SVH
`define GROUND_MOTION_INTENSITY_MEASURES_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GMIM_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gmim assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GMIM_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gmim assertion failed");

`endif

### rtl/gmim_pkg.sv
// Package: widths, constants, control struct and helpers of the ground-motion block.
`timescale 1ns / 1ps
package gmim_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int DT_W        = 16;
	localparam int VEL_W       = 56;
	localparam int PEAK_V_W    = 55;
	localparam int PEAK_A_W    = 24;
	localparam int ARIAS_W     = 56;
	localparam int SQ_SUM_W    = 64;
	localparam int GAIN_W      = 30;
	localparam int ARIAS_SHIFT = 32;
	localparam int SQ_SHIFT    = 17;

	localparam logic [DT_W-1:0]     DT_RESET   = 16'd655;
	localparam logic [GAIN_W-1:0]   ARIAS_GAIN = 30'd688420291;
	localparam logic [PEAK_A_W-1:0] PEAK_A_MAX = '1;
	localparam logic [VEL_W-1:0]    VEL_MIN    = {1'b1, {(VEL_W-1){1'b0}}};
	localparam logic [VEL_W-1:0]    VEL_MAX    = {1'b0, {(VEL_W-1){1'b1}}};

	// Velocity path: sample pair sum, product with dt, halved increment.
	localparam int MAG_W   = SAMPLE_BITS;
	localparam int SUM_W   = SAMPLE_BITS + 1;
	localparam int VPROD_W = SUM_W + DT_W;
	localparam int DV_W    = VPROD_W - 1;

	// Energy path: squares, their pair sum, scaled increment, gain product.
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int TERM_W      = SQ_W + 1;
	localparam int INC_W       = TERM_W + DT_W - SQ_SHIFT;
	localparam int ACC_W       = (TERM_W > SQ_SUM_W) ? TERM_W : SQ_SUM_W;
	localparam int ARIAS_RAW_W = SQ_SUM_W + GAIN_W - ARIAS_SHIFT;

	// Multiplier shift register holds the longest operand that is shifted out.
	localparam int X_W = (SAMPLE_BITS > GAIN_W)
		? ((SAMPLE_BITS > DT_W) ? SAMPLE_BITS : DT_W)
		: ((GAIN_W > DT_W) ? GAIN_W : DT_W);
	localparam int CNT_W  = $clog2(X_W + 1);
	localparam int CLIP_W = (SAMPLE_BITS > PEAK_A_W) ? SAMPLE_BITS : PEAK_A_W;

	typedef struct packed {
		logic load;        // request accepted: latch operands
		logic clear;       // request starts a new record
		logic integrate;   // this request adds area
		logic eng_step;    // one shift-add step of the energy engine
		logic vel_step;    // one shift-add step of the velocity engine
		logic square_end;  // sample square is complete
		logic scale_end;   // dt products are complete
		logic gain_end;    // Arias gain product is complete
	} gmim_ctrl_t;

	function automatic logic [PEAK_A_W-1:0] clip_accel(input logic [MAG_W-1:0] m);
		logic [CLIP_W-1:0] w;
		w = CLIP_W'(m);
		if (w > CLIP_W'(PEAK_A_MAX))
			return PEAK_A_MAX;
		return PEAK_A_W'(w);
	endfunction

endpackage

### rtl/gmim_if.sv
// Stream interfaces: acceleration samples in, intensity measures out.
`timescale 1ns / 1ps
interface gmim_sample_if import gmim_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] accel;
	logic                          start_req;

	modport source (output valid, output accel, output start_req, input ready);
	modport sink   (input valid, input accel, input start_req, output ready);
endinterface

interface gmim_result_if import gmim_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] velocity;
	logic [PEAK_V_W-1:0]     peak_velocity;
	logic [PEAK_A_W-1:0]     peak_accel;
	logic [ARIAS_W-1:0]      arias;

	modport source (output valid, output velocity, output peak_velocity,
		output peak_accel, output arias, input ready);
	modport sink   (input valid, input velocity, input peak_velocity,
		input peak_accel, input arias, output ready);
endinterface

### rtl/gmim_vel_unit.sv
// Velocity unit: bit-serial trapezoid product, saturating integrator, peak tracker.
`timescale 1ns / 1ps
module gmim_vel_unit import gmim_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gmim_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] accel,
	input  logic [DT_W-1:0]               dt,
	output logic signed [VEL_W-1:0]       velocity,
	output logic [PEAK_V_W-1:0]           peak_velocity
);

	logic signed [SAMPLE_BITS-1:0] prev_a_q;
	logic [SUM_W-1:0]              mcand_q;
	logic [SUM_W-1:0]              acc_q;
	logic [DT_W-1:0]               x_q;
	logic [SUM_W:0]                step_sum;
	logic [VPROD_W-1:0]            prod;
	logic [DV_W-1:0]               dv;
	logic [VEL_W:0]                v_sum;
	logic [VEL_W-1:0]              v_next;
	logic [VEL_W-1:0]              v_q;
	logic [VEL_W-1:0]              v_mag;
	logic [PEAK_V_W-1:0]           v_clip;
	logic [PEAK_V_W-1:0]           peak_q;

	always_comb begin
		// signed multiplicand, unsigned dt: sign-extend before each add
		step_sum = {acc_q[SUM_W-1], acc_q}
			+ (x_q[0] ? {mcand_q[SUM_W-1], mcand_q} : '0);
		prod = {acc_q, x_q};
		dv = prod[VPROD_W-1:1];
		v_sum = {v_q[VEL_W-1], v_q} + {{(VEL_W+1-DV_W){dv[DV_W-1]}}, dv};
		if (v_sum[VEL_W] != v_sum[VEL_W-1])
			v_next = v_sum[VEL_W] ? VEL_MIN : VEL_MAX;
		else
			v_next = v_sum[VEL_W-1:0];
		v_mag = v_q[VEL_W-1] ? (~v_q + VEL_W'(1)) : v_q;
		v_clip = v_mag[VEL_W-1] ? '1 : v_mag[PEAK_V_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			peak_q <= '0;
		end else if (ctrl.clear) begin
			v_q    <= '0;
			peak_q <= '0;
		end else begin
			if (ctrl.scale_end && ctrl.integrate)
				v_q <= v_next;
			if (ctrl.gain_end && (v_clip > peak_q))
				peak_q <= v_clip;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prev_a_q <= accel;
			mcand_q  <= {prev_a_q[SAMPLE_BITS-1], prev_a_q} + {accel[SAMPLE_BITS-1], accel};
			acc_q    <= '0;
			x_q      <= dt;
		end else if (ctrl.vel_step) begin
			acc_q <= step_sum[SUM_W:1];
			x_q   <= {step_sum[0], x_q[DT_W-1:1]};
		end
	end

	assign velocity      = v_q;
	assign peak_velocity = peak_q;

endmodule

### rtl/gmim_arias_unit.sv
// Energy unit: one shared shift-add engine for square, dt scaling and Arias gain.
`timescale 1ns / 1ps
module gmim_arias_unit import gmim_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  gmim_ctrl_t         ctrl,
	input  logic [MAG_W-1:0]   mag,
	input  logic [DT_W-1:0]    dt,
	output logic [ARIAS_W-1:0] arias
);

	logic [ACC_W-1:0]              mcand_q;
	logic [ACC_W-1:0]              acc_q;
	logic [X_W-1:0]                x_q;
	logic [SQ_W-1:0]               prev_sq_q;
	logic [SQ_SUM_W-1:0]           sq_sum_q;
	logic [ARIAS_W-1:0]            arias_q;
	logic [ACC_W:0]                step_sum;
	logic [SQ_W-1:0]               a_sq;
	logic [TERM_W-1:0]             term;
	logic [TERM_W+DT_W-1:0]        scale_prod;
	logic [INC_W-1:0]              inc;
	logic [SQ_SUM_W:0]             sq_add;
	logic [SQ_SUM_W-1:0]           sq_next;
	logic [SQ_SUM_W-1:0]           sq_upd;
	logic [SQ_SUM_W+GAIN_W-1:0]    gain_prod;
	logic [ARIAS_RAW_W-1:0]        arias_raw;
	logic [ARIAS_W-1:0]            arias_next;

	always_comb begin
		step_sum = {1'b0, acc_q} + (x_q[0] ? {1'b0, mcand_q} : '0);
		// low product bits land at the top of the multiplier register
		a_sq = {acc_q[MAG_W-1:0], x_q[X_W-1 -: MAG_W]};
		term = {1'b0, prev_sq_q} + {1'b0, a_sq};
		scale_prod = {acc_q[TERM_W-1:0], x_q[X_W-1 -: DT_W]};
		inc = scale_prod[TERM_W+DT_W-1:SQ_SHIFT];
		sq_add = {1'b0, sq_sum_q} + (SQ_SUM_W+1)'(inc);
		sq_next = sq_add[SQ_SUM_W] ? '1 : sq_add[SQ_SUM_W-1:0];
		sq_upd = ctrl.integrate ? sq_next : sq_sum_q;
		gain_prod = {acc_q[SQ_SUM_W-1:0], x_q[X_W-1 -: GAIN_W]};
		arias_raw = gain_prod[SQ_SUM_W+GAIN_W-1:ARIAS_SHIFT];
		arias_next = (|arias_raw[ARIAS_RAW_W-1:ARIAS_W]) ? '1 : arias_raw[ARIAS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_sum_q <= '0;
		else if (ctrl.clear)
			sq_sum_q <= '0;
		else if (ctrl.scale_end)
			sq_sum_q <= sq_upd;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mcand_q <= ACC_W'(mag);
			acc_q   <= '0;
			x_q     <= X_W'(mag);
		end else if (ctrl.square_end) begin
			prev_sq_q <= a_sq;
			mcand_q   <= ACC_W'(term);
			acc_q     <= '0;
			x_q       <= X_W'(dt);
		end else if (ctrl.scale_end) begin
			mcand_q <= ACC_W'(sq_upd);
			acc_q   <= '0;
			x_q     <= X_W'(ARIAS_GAIN);
		end else if (ctrl.gain_end) begin
			arias_q <= arias_next;
		end else if (ctrl.eng_step) begin
			acc_q <= step_sum[ACC_W:1];
			x_q   <= {step_sum[0], x_q[X_W-1:1]};
		end
	end

	assign arias = arias_q;

endmodule

### rtl/ground_motion_intensity_measures_core.sv
// Top level of the ground-motion intensity block: sequencer, peak acceleration, result register.
// Takes one acceleration request at a time (Q8.16 m/s^2, start_req begins a new record)
// and returns one result per request: trapezoidal velocity, peak |velocity|, peak
// |acceleration| and Arias intensity, all running values of the current record. The
// sample interval dt is set through cfg_we/cfg_wdata in units of 2^-16 s (655 after
// reset); write it only while no request is in flight. After acceptance a request passes
// through the accept cycle, the squaring of the sample, the scaling by dt, the Arias
// gain and the hand-over of the result to the output register, which waits until that
// register is free or being drained; then the block is ready again. The shift-add
// engine of the energy unit, one bit per cycle, runs these three products back to back;
// the velocity product runs beside it during the dt phase. A finished
// result waits in the output register, and the next request is taken while it waits.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
module ground_motion_intensity_measures_core import gmim_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [DT_W-1:0]   cfg_wdata,
	gmim_sample_if.sink       samples,
	gmim_result_if.source     measures
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SCALE,
		ST_GAIN,
		ST_HOLD
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    integ_q;
	logic                    have_prev_q;
	logic [PEAK_A_W-1:0]     peak_a_q;
	logic [DT_W-1:0]         dt_q;
	logic                    out_valid_q;
	logic [VEL_W-1:0]        out_vel_q;
	logic [PEAK_V_W-1:0]     out_pv_q;
	logic [PEAK_A_W-1:0]     out_pa_q;
	logic [ARIAS_W-1:0]      out_arias_q;

	logic                    in_fire;
	logic                    out_load;
	logic                    running;
	logic [MAG_W-1:0]        a_mag;
	logic [PEAK_A_W-1:0]     a_clip;
	logic [PEAK_A_W-1:0]     peak_base;
	gmim_ctrl_t              ctrl;
	logic signed [VEL_W-1:0] vel;
	logic [PEAK_V_W-1:0]     peak_vel;
	logic [ARIAS_W-1:0]      arias;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_fire  = samples.valid && samples.ready;
	// hand over only when the output register is free or being drained
	assign out_load = (state_q == ST_HOLD) && (!out_valid_q || measures.ready);
	assign running  = (state_q == ST_SQUARE) || (state_q == ST_SCALE) || (state_q == ST_GAIN);

	always_comb begin
		// magnitude of the most negative sample still fits MAG_W unsigned bits
		a_mag = samples.accel[SAMPLE_BITS-1] ? MAG_W'(-samples.accel) : MAG_W'(samples.accel);
		a_clip = clip_accel(a_mag);
		peak_base = samples.start_req ? '0 : peak_a_q;

		ctrl.load       = in_fire;
		ctrl.clear      = in_fire && samples.start_req;
		ctrl.integrate  = integ_q;
		ctrl.eng_step   = running && (cnt_q != '0);
		ctrl.vel_step   = (state_q == ST_SCALE) && (cnt_q != '0);
		ctrl.square_end = (state_q == ST_SQUARE) && (cnt_q == '0);
		ctrl.scale_end  = (state_q == ST_SCALE) && (cnt_q == '0);
		ctrl.gain_end   = (state_q == ST_GAIN) && (cnt_q == '0);
	end

	// Configuration register: dt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dt_q <= DT_RESET;
		else if (cfg_we)
			dt_q <= cfg_wdata;
	end

	// Sequencer, record flags, peak acceleration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			integ_q     <= 1'b0;
			have_prev_q <= 1'b0;
			peak_a_q    <= '0;
			out_valid_q <= 1'b0;
			out_vel_q   <= '0;
			out_pv_q    <= '0;
			out_pa_q    <= '0;
			out_arias_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						// the first sample of a record adds no area
						integ_q     <= have_prev_q && !samples.start_req;
						have_prev_q <= 1'b1;
						peak_a_q    <= (a_clip > peak_base) ? a_clip : peak_base;
						cnt_q       <= CNT_W'(SAMPLE_BITS);
						state_q     <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else begin
						cnt_q   <= CNT_W'(DT_W);
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else begin
						cnt_q   <= CNT_W'(GAIN_W);
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - CNT_W'(1);
					else
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_vel_q   <= vel;
				out_pv_q    <= peak_vel;
				out_pa_q    <= peak_a_q;
				out_arias_q <= arias;
			end else if (measures.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	gmim_vel_unit u_vel (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.accel         (samples.accel),
		.dt            (dt_q),
		.velocity      (vel),
		.peak_velocity (peak_vel)
	);

	gmim_arias_unit u_arias (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.mag    (a_mag),
		.dt     (dt_q),
		.arias  (arias)
	);

	assign measures.valid         = out_valid_q;
	assign measures.velocity      = out_vel_q;
	assign measures.peak_velocity = out_pv_q;
	assign measures.peak_accel    = out_pa_q;
	assign measures.arias         = out_arias_q;

endmodule

### rtl/gmim_checker.sv
// Port-level checker for the ground-motion block and its bind statement.
`timescale 1ns / 1ps
`include "ground_motion_intensity_measures_core_assert.svh"
module gmim_checker import gmim_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_valid,
	input logic                    s_ready,
	input logic                    m_valid,
	input logic                    m_ready,
	input logic signed [VEL_W-1:0] m_velocity,
	input logic [PEAK_V_W-1:0]     m_peak_velocity,
	input logic [PEAK_A_W-1:0]     m_peak_accel,
	input logic [ARIAS_W-1:0]      m_arias
);

	logic [VEL_W-1:0]    vabs;
	logic [PEAK_V_W-1:0] vclip;

	always_comb begin
		vabs  = m_velocity[VEL_W-1] ? VEL_W'(-m_velocity) : VEL_W'(m_velocity);
		vclip = vabs[VEL_W-1] ? '1 : vabs[PEAK_V_W-1:0];
	end

	// one request at a time: busy right after an accept
	`GMIM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_valid && s_ready, !s_ready)
	`GMIM_ASSERT_NEXT(a_result_held, clk, arst_n, m_valid && !m_ready, m_valid)
	`GMIM_ASSERT_NEXT(a_payload_held, clk, arst_n, m_valid && !m_ready, $stable(m_velocity) && $stable(m_peak_velocity) && $stable(m_peak_accel) && $stable(m_arias))
	// the peak always covers the velocity shown with it
	`GMIM_ASSERT_NOW(a_peak_covers_velocity, clk, arst_n, m_valid, m_peak_velocity >= vclip)

endmodule

bind ground_motion_intensity_measures_core gmim_checker u_gmim_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.s_valid         (samples.valid),
	.s_ready         (samples.ready),
	.m_valid         (measures.valid),
	.m_ready         (measures.ready),
	.m_velocity      (measures.velocity),
	.m_peak_velocity (measures.peak_velocity),
	.m_peak_accel    (measures.peak_accel),
	.m_arias         (measures.arias)
);

### tb/sv/testbench.sv
// Self-checking bench for the ground-motion intensity core: scripted and random samples.
`timescale 1ns / 1ps
module testbench;
	import gmim_pkg::*;

	// One result of the core: running velocity, its peak, peak acceleration, Arias.
	typedef struct packed {
		logic signed [VEL_W-1:0] velocity;
		logic [PEAK_V_W-1:0]     peak_velocity;
		logic [PEAK_A_W-1:0]     peak_accel;
		logic [ARIAS_W-1:0]      arias;
	} measure_t;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	// One scripted step: either a sample request or an interval write.
	typedef struct {
		row_kind_t                     kind;
		logic signed [SAMPLE_BITS-1:0] accel;
		logic                          start_req;
		logic                          typed;
		measure_t                      want;
		logic [DT_W-1:0]               interval;
	} script_row_t;

	localparam logic signed [SAMPLE_BITS-1:0] ACCEL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] ACCEL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [DT_W-1:0] RESET_INTERVAL = 16'd655;
	localparam longint          VEL_TOP        = 64'sh007F_FFFF_FFFF_FFFF;
	localparam longint          VEL_BOTTOM     = -VEL_TOP - 64'sd1;
	localparam longint unsigned ARIAS_TOP      = 64'h00FF_FFFF_FFFF_FFFF;
	localparam longint unsigned GAIN_Q32       = 64'd688420291;   // pi/19.6 in Q0.32
	localparam int              SCRIPT_LEN     = 23;
	localparam int              PHASES         = 12;
	localparam int              PER_PHASE      = 153;
	localparam int              QUIET_LIMIT    = 5000;
	localparam int              HOLD_CYCLES    = 400;
	localparam int              DRAIN_CYCLES   = 100;
	localparam measure_t        NO_WANT        = '0;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [DT_W-1:0] cfg_wdata;

	gmim_sample_if sample_bus ();
	gmim_result_if measure_bus ();

	ground_motion_intensity_measures_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (sample_bus),
		.measures  (measure_bus)
	);

	// Mirror of the core's record state, advanced at every accepted request.
	logic signed [SAMPLE_BITS-1:0] last_accel;
	logic                          have_last;
	logic signed [VEL_W-1:0]       vel_model;
	logic [PEAK_V_W-1:0]           vel_peak_model;
	logic [PEAK_A_W-1:0]           accel_peak_model;
	logic [63:0]                   energy_model;
	logic [DT_W-1:0]               interval_model;

	measure_t expected_measures[$];
	int       errors;
	logic     tx_calm;

	// Scripted opening: extremes, start handling, zero and extreme intervals. Rows with a
	// typed result are first samples of a record, zero-interval rows or runs of zero samples,
	// where velocity, its peak and Arias stay 0 and the acceleration peak is the largest sample magnitude so far.
	script_row_t script [SCRIPT_LEN] = '{
		'{ROW_SAMPLE, ACCEL_MIN,  1'b0, 1'b1, '{56'sd0, 55'd0, 24'h800000, 56'd0}, 16'd0},
		'{ROW_SAMPLE, ACCEL_MAX,  1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_SAMPLE, ACCEL_MAX,  1'b1, 1'b1, '{56'sd0, 55'd0, 24'h7FFFFF, 56'd0}, 16'd0},
		'{ROW_SAMPLE, ACCEL_MAX,  1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_SAMPLE, 24'sd0,     1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_SAMPLE, -24'sd1,    1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_SAMPLE, 24'sd1,     1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_CFG,    24'sd0,     1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_SAMPLE, ACCEL_MAX,  1'b1, 1'b1, '{56'sd0, 55'd0, 24'h7FFFFF, 56'd0}, 16'd0},
		'{ROW_SAMPLE, ACCEL_MIN,  1'b0, 1'b1, '{56'sd0, 55'd0, 24'h800000, 56'd0}, 16'd0},
		'{ROW_SAMPLE, 24'sd12345, 1'b0, 1'b1, '{56'sd0, 55'd0, 24'h800000, 56'd0}, 16'd0},
		'{ROW_CFG,    24'sd0,     1'b0, 1'b0, NO_WANT, 16'd65535},
		'{ROW_SAMPLE, 24'sd0,     1'b1, 1'b1, NO_WANT, 16'd0},
		'{ROW_SAMPLE, ACCEL_MIN,  1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_SAMPLE, ACCEL_MIN,  1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_SAMPLE, ACCEL_MAX,  1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_CFG,    24'sd0,     1'b0, 1'b0, NO_WANT, 16'd1},
		'{ROW_SAMPLE, 24'sd100,   1'b1, 1'b1, '{56'sd0, 55'd0, 24'd100, 56'd0}, 16'd0},
		'{ROW_SAMPLE, 24'sd100,   1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_SAMPLE, -24'sd3,    1'b0, 1'b0, NO_WANT, 16'd0},
		'{ROW_CFG,    24'sd0,     1'b0, 1'b0, NO_WANT, 16'd655},
		'{ROW_SAMPLE, 24'sd0,     1'b1, 1'b1, NO_WANT, 16'd0},
		'{ROW_SAMPLE, 24'sd0,     1'b0, 1'b1, NO_WANT, 16'd0}
	};

	// Free-running clock, 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Idle length: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 20);
		return $urandom_range(60, 200);
	endfunction

	// Advance the record state by one sample and return the measures it yields.
	function automatic measure_t take_sample(input logic signed [SAMPLE_BITS-1:0] a,
			input logic start);
		longint          cur;
		longint          prv;
		longint          step;
		longint          vsum;
		longint unsigned cur_mag;
		longint unsigned prv_mag;
		longint unsigned vel_mag;
		longint unsigned squares;
		longint unsigned area;
		longint unsigned arias;
		measure_t        m;
		// Start wipes the whole record before this sample counts.
		if (start) begin
			last_accel       = '0;
			have_last        = 1'b0;
			vel_model        = '0;
			vel_peak_model   = '0;
			accel_peak_model = '0;
			energy_model     = '0;
		end
		cur = longint'(a);
		prv = longint'(last_accel);
		cur_mag = (cur < 0) ? longint'(-cur) : cur;
		prv_mag = (prv < 0) ? longint'(-prv) : prv;
		if (cur_mag > accel_peak_model)
			accel_peak_model = PEAK_A_W'(cur_mag);
		// The first sample of a record has no partner, so it adds no area.
		if (have_last) begin
			step = ((prv + cur) * longint'(interval_model)) >>> 1;
			vsum = longint'(vel_model) + step;
			if (vsum > VEL_TOP)
				vsum = VEL_TOP;
			if (vsum < VEL_BOTTOM)
				vsum = VEL_BOTTOM;
			vel_model = VEL_W'(vsum);
			// Pair of squares fits in 48 bits, so the dt product stays below 2^63.
			squares = prv_mag * prv_mag + cur_mag * cur_mag;
			area = (squares * 64'(interval_model)) >> 17;
			if (energy_model > ~64'd0 - area)
				energy_model = '1;
			else
				energy_model = energy_model + area;
		end
		last_accel = a;
		have_last  = 1'b1;
		vsum = longint'(vel_model);
		vel_mag = (vsum < 0) ? longint'(-vsum) : vsum;
		if (vel_mag > VEL_TOP)
			vel_mag = VEL_TOP;
		if (vel_mag > vel_peak_model)
			vel_peak_model = PEAK_V_W'(vel_mag);
		// Scale the square sum by the gain in two halves to keep it within 64 bits.
		arias = (energy_model >> 32) * GAIN_Q32
			+ ((64'(energy_model[31:0]) * GAIN_Q32) >> 32);
		if (arias > ARIAS_TOP)
			arias = ARIAS_TOP;
		m.velocity      = vel_model;
		m.peak_velocity = vel_peak_model;
		m.peak_accel    = accel_peak_model;
		m.arias         = ARIAS_W'(arias);
		return m;
	endfunction

	// Append one expectation at the tail of the result queue.
	task automatic queue_result(input measure_t m);
		expected_measures = {expected_measures, m};
	endtask

	task automatic flag_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	// Offer one sample request, hold it until taken, then queue what it must produce.
	// Enter and leave at a falling edge; valid stays high when the next request follows.
	task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] a, input logic start,
			input logic typed, input measure_t want);
		int unsigned idle;
		measure_t    predicted;
		idle = tx_calm ? 0 : pick_gap();
		if (idle != 0) begin
			sample_bus.valid = 1'b0;
			repeat (idle) @(negedge clk);
		end
		sample_bus.valid     = 1'b1;
		sample_bus.accel     = a;
		sample_bus.start_req = start;
		do
			@(posedge clk);
		while (!sample_bus.ready);
		predicted = take_sample(a, start);
		queue_result(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Drain every outstanding request, then write the sample interval.
	task automatic write_interval(input logic [DT_W-1:0] value);
		sample_bus.valid = 1'b0;
		while (expected_measures.size() != 0)
			@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		interval_model = value;
	endtask

	// Stimulus: reset, scripted rows, then random records over several intervals.
	initial begin : stimulus
		logic [DT_W-1:0] fixed_intervals [6];
		logic signed [SAMPLE_BITS-1:0] a;
		logic signed [17:0] tiny;
		logic signed [20:0] mid21;
		logic start;
		int unsigned rec_left;
		int ph;
		int n;
		fixed_intervals = '{16'd65535, 16'd1, 16'd0, 16'd655, 16'd32768, 16'd2};
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		sample_bus.valid     = 1'b0;
		sample_bus.accel     = '0;
		sample_bus.start_req = 1'b0;
		tx_calm              = 1'b0;
		errors               = 0;
		rec_left             = 0;
		last_accel           = '0;
		have_last            = 1'b0;
		vel_model            = '0;
		vel_peak_model       = '0;
		accel_peak_model     = '0;
		energy_model         = '0;
		interval_model       = RESET_INTERVAL;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the script; the first row deliberately carries no start flag.
		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				write_interval(script[i].interval);
			else
				offer_sample(script[i].accel, script[i].start_req, script[i].typed,
					script[i].want);
		end

		// Random records: mostly well-formed with a start flag, a few missing it, and
		// stray starts in the middle of a record.
		for (ph = 0; ph < PHASES; ph++) begin
			write_interval((ph % 2) ? DT_W'($urandom_range(1, 65535))
				: fixed_intervals[ph / 2]);
			tx_calm = (ph % 4 == 3);
			for (n = 0; n < PER_PHASE; n++) begin
				if (rec_left == 0) begin
					start    = ($urandom_range(0, 9) != 0);
					rec_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
						: $urandom_range(2, 40);
				end else begin
					start = ($urandom_range(0, 49) == 0);
					rec_left--;
				end
				tiny  = 18'($urandom);
				mid21 = 21'($urandom);
				case ($urandom_range(0, 19))
					0:          a = ACCEL_MIN;
					1:          a = ACCEL_MAX;
					2:          a = '0;
					3, 4, 5, 6: a = SAMPLE_BITS'($urandom);
					7, 8, 9:    a = SAMPLE_BITS'(mid21);
					default:    a = SAMPLE_BITS'(tiny);
				endcase
				offer_sample(a, start, 1'b0, NO_WANT);
			end
		end
		sample_bus.valid = 1'b0;

		// Wait out every outstanding result, then watch for strays.
		while (expected_measures.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ground_motion_intensity_measures_core verification clean");
		else
			$display("ground_motion_intensity_measures_core verification failed");
		$finish;
	end

	// Result side: drive ready with random stalls, compare each result with the oldest
	// expectation. Hold off long twice so the core fills up and stalls its input.
	initial begin : result_side
		int unsigned hold_left;
		int unsigned got;
		logic        rx_calm;
		measure_t    want;
		hold_left = 0;
		got       = 0;
		rx_calm   = 1'b0;
		measure_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			measure_bus.ready = (hold_left == 0);
			if (hold_left != 0)
				hold_left--;
			@(posedge clk);
			if (measure_bus.valid && measure_bus.ready) begin
				if (expected_measures.size() == 0) begin
					$display("%0t: result with no request pending, expected none, got %0d",
						$time, measure_bus.velocity);
					errors++;
				end else begin
					want = expected_measures.pop_front();
					flag_field("velocity", want.velocity, measure_bus.velocity);
					flag_field("peak_velocity", want.peak_velocity, measure_bus.peak_velocity);
					flag_field("peak_accel", want.peak_accel, measure_bus.peak_accel);
					flag_field("arias", want.arias, measure_bus.arias);
				end
				got++;
				if (got % 64 == 0)
					rx_calm = ($urandom_range(0, 3) == 0);
				if (got == 300 || got == 1200)
					hold_left = HOLD_CYCLES;
				else if (!rx_calm)
					hold_left = pick_gap();
			end
		end
	end

	// Watchdog: end the run when nothing moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_bus.valid && sample_bus.ready)
					|| (measure_bus.valid && measure_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
		$display("ground_motion_intensity_measures_core verification failed");
		$finish;
	end

endmodule
